// File: rtl/rar_pkg.sv
`default_nettype none

package rar_pkg;

    // operation codes carried in s_axis_tuser
    localparam logic [1:0] ACT_MUL = 2'd0;
    localparam logic [1:0] ACT_DIV = 2'd1;
    localparam logic [1:0] ACT_ADD = 2'd2;
    localparam logic [1:0] ACT_SUB = 2'd3;

    localparam int ACT_W     = 2;
    localparam int RES_NUM_W = 33;
    localparam int RES_DEN_W = 31;
    localparam int M_DW      = 64;

endpackage

`default_nettype wire

// File: rtl/rational_arith_reduce_unit.sv
// Channel  Direction  Payload
// s_axis   in         tuser: action; tdata: a_num, a_den, b_num, b_den (OPERAND_WIDTH each)
// m_axis   out        tuser: zero_den_error; tdata: res_num (33), res_den (31)
//
// One transaction: the product and sum steps (MUL1, MUL2 for multiply and divide; MUL3
// and ACCUM as well for add and subtract), a check step, binary-GCD steps, restoring
// divisions of NW bits for the numerator, then the denominator (NW = min(2*OPERAND_WIDTH+1,
// 64)) and an output step; a zero numerator or denominator goes from the check to the output.
// Reset (aresetn low at a clock edge) empties the output register and idles the block.
// The output register holds a result while m_axis_tready is low; s_axis_tready is high
// whenever the sequencer is idle, even while a result waits there.
`default_nettype none

module rational_arith_reduce_unit
    import rar_pkg::*;
#(
    parameter int OPERAND_WIDTH = 16
) (
    input  wire logic                                         aclk,
    input  wire logic                                         aresetn,
    input  wire logic                                         s_axis_tvalid,
    output logic                                              s_axis_tready,
    // a_num, a_den, b_num, b_den from bit 0 up, zero padded to bytes
    input  wire logic [((4*OPERAND_WIDTH+7)/8)*8-1:0]         s_axis_tdata,
    // action
    input  wire logic [ACT_W-1:0]                             s_axis_tuser,
    output logic                                              m_axis_tvalid,
    input  wire logic                                         m_axis_tready,
    // res_num, res_den from bit 0 up
    output logic [M_DW-1:0]                                   m_axis_tdata,
    // zero_den_error
    output logic [0:0]                                        m_axis_tuser
);

    localparam int W   = OPERAND_WIDTH;
    localparam int PW  = 2 * W;
    localparam int NW  = (2 * W + 1 > 64) ? 64 : 2 * W + 1;
    localparam int CW  = $clog2(NW);
    localparam int KW  = $clog2(NW + 1);
    localparam int XW  = (NW > RES_NUM_W) ? NW : RES_NUM_W;
    localparam int DXW = (NW > RES_DEN_W) ? NW : RES_DEN_W;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MUL1  = 4'd1;
    localparam logic [3:0] ST_MUL2  = 4'd2;
    localparam logic [3:0] ST_MUL3  = 4'd3;
    localparam logic [3:0] ST_ACCUM = 4'd4;
    localparam logic [3:0] ST_CHECK = 4'd5;
    localparam logic [3:0] ST_GCD   = 4'd6;
    localparam logic [3:0] ST_DIVN  = 4'd7;
    localparam logic [3:0] ST_DIVD  = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;

    logic [3:0]           state_reg, state_next;
    logic [ACT_W-1:0]     act_reg;
    logic signed [W-1:0]  an_reg, ad_reg, bn_reg, bd_reg;
    logic [NW-1:0]        n_reg;
    logic [PW-1:0]        d_reg, p_reg;
    logic                 neg_reg;
    logic [NW-1:0]        mn_reg, x_reg, y_reg, g_reg, rem_reg, dq_reg;
    logic [PW-1:0]        md_reg;
    logic [KW-1:0]        k_reg;
    logic [CW-1:0]        cnt_reg;
    logic [RES_NUM_W-1:0] res_num_reg, m_num_reg;
    logic [RES_DEN_W-1:0] res_den_reg, m_den_reg;
    logic                 res_err_reg, m_err_reg, m_valid_reg;

    logic signed [W-1:0]  mul_a, mul_b;
    logic signed [PW-1:0] prod;
    logic [NW-1:0]        prod_ext, p_ext, n_mag;
    logic [PW-1:0]        d_mag;
    logic [NW:0]          diff_xy;
    logic [NW-1:0]        diff_yx;
    logic [NW:0]          rem_sh;
    logic [NW+1:0]        trial;
    logic                 fits;
    logic [NW-1:0]        quo;
    logic [XW-1:0]        quo_wide, num_signed;
    logic [DXW-1:0]       den_wide;
    logic                 out_free;

    // shared multiplier: operand pair chosen by sequencer step
    always_comb begin
        mul_a = an_reg;
        mul_b = bd_reg;
        case (state_reg)
            ST_MUL1: begin
                mul_a = an_reg;
                mul_b = (act_reg == ACT_MUL) ? bn_reg : bd_reg;
            end
            ST_MUL2: begin
                mul_a = ad_reg;
                mul_b = (act_reg == ACT_DIV) ? bn_reg : bd_reg;
            end
            ST_MUL3: begin
                mul_a = bn_reg;
                mul_b = ad_reg;
            end
            default: begin
                mul_a = an_reg;
                mul_b = bd_reg;
            end
        endcase
    end

    assign prod     = mul_a * mul_b;
    assign prod_ext = NW'(prod);
    assign p_ext    = NW'(signed'(p_reg));
    assign n_mag    = n_reg[NW-1] ? (~n_reg + 1'b1) : n_reg;
    assign d_mag    = d_reg[PW-1] ? (~d_reg + 1'b1) : d_reg;

    // subtractors for the GCD steps (x - y and y - x)
    assign diff_xy = {1'b0, x_reg} - {1'b0, y_reg};
    assign diff_yx = y_reg - x_reg;

    // one restoring division step
    assign rem_sh   = {rem_reg, dq_reg[NW-1]};
    assign trial    = {1'b0, rem_sh} - {2'b00, g_reg};
    assign fits     = !trial[NW+1];
    assign quo      = {dq_reg[NW-2:0], fits};
    assign quo_wide = XW'(quo);
    assign num_signed = neg_reg ? (~quo_wide + 1'b1) : quo_wide;
    assign den_wide = DXW'(quo);

    assign out_free = !m_valid_reg || m_axis_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_axis_tvalid) state_next = ST_MUL1;
            ST_MUL1:  state_next = ST_MUL2;
            ST_MUL2: begin
                if (act_reg == ACT_ADD || act_reg == ACT_SUB) begin
                    state_next = ST_MUL3;
                end else begin
                    state_next = ST_CHECK;
                end
            end
            ST_MUL3:  state_next = ST_ACCUM;
            ST_ACCUM: state_next = ST_CHECK;
            ST_CHECK: begin
                if (d_reg == '0 || n_reg == '0) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_GCD;
                end
            end
            ST_GCD:   if (x_reg == y_reg) state_next = ST_DIVN;
            ST_DIVN:  if (cnt_reg == '0) state_next = ST_DIVD;
            ST_DIVD:  if (cnt_reg == '0) state_next = ST_OUT;
            ST_OUT:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                act_reg <= s_axis_tuser;
                an_reg  <= s_axis_tdata[W-1:0];
                ad_reg  <= s_axis_tdata[2*W-1:W];
                bn_reg  <= s_axis_tdata[3*W-1:2*W];
                bd_reg  <= s_axis_tdata[4*W-1:3*W];
            end
            ST_MUL1: n_reg <= prod_ext;
            ST_MUL2: d_reg <= prod;
            ST_MUL3: p_reg <= prod;
            ST_ACCUM: begin
                n_reg <= (act_reg == ACT_ADD) ? n_reg + p_ext : n_reg - p_ext;
            end
            ST_CHECK: begin
                if (d_reg == '0) begin
                    res_num_reg <= '0;
                    res_den_reg <= '0;
                    res_err_reg <= 1'b1;
                end else begin
                    res_err_reg <= 1'b0;
                    if (n_reg == '0) begin
                        res_num_reg <= '0;
                        res_den_reg <= RES_DEN_W'(1);
                    end
                end
                mn_reg  <= n_mag;
                md_reg  <= d_mag;
                x_reg   <= n_mag;
                y_reg   <= NW'(d_mag);
                k_reg   <= '0;
                neg_reg <= n_reg[NW-1] ^ d_reg[PW-1];
            end
            ST_GCD: begin
                if (x_reg == y_reg) begin
                    // gcd = common odd part times the common power of two
                    g_reg   <= x_reg << k_reg;
                    rem_reg <= '0;
                    dq_reg  <= mn_reg;
                    cnt_reg <= CW'(NW - 1);
                end else if (!x_reg[0] && !y_reg[0]) begin
                    x_reg <= x_reg >> 1;
                    y_reg <= y_reg >> 1;
                    k_reg <= k_reg + 1'b1;
                end else if (!x_reg[0]) begin
                    x_reg <= x_reg >> 1;
                end else if (!y_reg[0]) begin
                    y_reg <= y_reg >> 1;
                end else if (!diff_xy[NW]) begin
                    x_reg <= diff_xy[NW-1:0] >> 1;
                end else begin
                    y_reg <= diff_yx >> 1;
                end
            end
            ST_DIVN: begin
                if (cnt_reg == '0) begin
                    res_num_reg <= num_signed[RES_NUM_W-1:0];
                    rem_reg     <= '0;
                    dq_reg      <= NW'(md_reg);
                    cnt_reg     <= CW'(NW - 1);
                end else begin
                    rem_reg <= fits ? trial[NW-1:0] : rem_sh[NW-1:0];
                    dq_reg  <= quo;
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
            ST_DIVD: begin
                rem_reg <= fits ? trial[NW-1:0] : rem_sh[NW-1:0];
                dq_reg  <= quo;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    res_den_reg <= den_wide[RES_DEN_W-1:0];
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_num_reg <= res_num_reg;
                    m_den_reg <= res_den_reg;
                    m_err_reg <= res_err_reg;
                end
            end
            default: begin
                // hold
            end
        endcase
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {m_den_reg, m_num_reg};
    assign m_axis_tuser  = m_err_reg;

endmodule

`default_nettype wire

// File: rtl/rar_port_chk.sv
`default_nettype none

module rar_port_chk
    import rar_pkg::*;
(
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             s_axis_tvalid,
    input wire logic             s_axis_tready,
    input wire logic             m_axis_tvalid,
    input wire logic             m_axis_tready,
    input wire logic [M_DW-1:0]  m_axis_tdata,
    input wire logic [0:0]       m_axis_tuser
);

    // reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("m_axis_tvalid high after reset");

    // the sequencer is busy right after taking a transaction
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("s_axis_tready high right after a transaction");

    // no result can appear in the cycle after an input transaction
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("result appeared too soon after input transaction");

    // a zero denominator reports 0/0
    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("error result with nonzero payload");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind rational_arith_reduce_unit rar_port_chk u_rar_port_chk (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// File: tb/tb_top.sv
`default_nettype none

module tb_top;
    import rar_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int OPERAND_W       = 16;
    localparam int S_DW            = ((4*OPERAND_W+7)/8)*8;
    localparam int HOLD_OFF_CYCLES = 700;
    localparam int DRAIN_CYCLES    = 300;
    localparam int CYCLE_LIMIT     = 1_000_000;

    typedef logic signed [OPERAND_W-1:0] operand_t;

    typedef struct packed {
        logic [RES_NUM_W-1:0] num;
        logic [RES_DEN_W-1:0] den;
        logic                 err;
    } reduced_fraction_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [S_DW-1:0]   s_axis_tdata = '0;
    logic [ACT_W-1:0]  s_axis_tuser = ACT_MUL;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [M_DW-1:0]   m_axis_tdata;
    logic [0:0]        m_axis_tuser;

    reduced_fraction_t expected_fractions[$];
    int unsigned       mismatch_count = 0;
    int unsigned       cycle_count = 0;
    bit                src_idle_on = 1'b0;
    logic              sink_idle_on = 1'b0;
    logic              sink_hold = 1'b0;
    int unsigned       sink_gap_left = 0;
    event              hold_off_trigger;

    rational_arith_reduce_unit #(
        .OPERAND_WIDTH(OPERAND_W)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Cross-multiply (and sum for add, subtract), then reduce by the gcd with the sign moved to the numerator.
    function automatic reduced_fraction_t reduce_fraction_op(input logic [ACT_W-1:0] act,
                                                             input operand_t an,
                                                             input operand_t ad,
                                                             input operand_t bn,
                                                             input operand_t bd);
        longint            n;
        longint            d;
        longint unsigned   mn;
        longint unsigned   md;
        longint unsigned   x;
        longint unsigned   y;
        longint unsigned   r;
        logic              neg;
        reduced_fraction_t res;
        case (act)
            ACT_MUL: begin
                n = longint'(an) * longint'(bn);
                d = longint'(ad) * longint'(bd);
            end
            ACT_DIV: begin
                n = longint'(an) * longint'(bd);
                d = longint'(ad) * longint'(bn);
            end
            ACT_ADD: begin
                n = longint'(an) * longint'(bd) + longint'(bn) * longint'(ad);
                d = longint'(ad) * longint'(bd);
            end
            default: begin
                n = longint'(an) * longint'(bd) - longint'(bn) * longint'(ad);
                d = longint'(ad) * longint'(bd);
            end
        endcase
        res = '0;
        if (d == 0) begin
            res.err = 1'b1;
        end else if (n == 0) begin
            res.den = RES_DEN_W'(1);
        end else begin
            neg = (n < 0) != (d < 0);
            mn  = (n < 0) ? longint'(-n) : n;
            md  = (d < 0) ? longint'(-d) : d;
            x   = mn;
            y   = md;
            while (y != 0) begin
                r = x % y;
                x = y;
                y = r;
            end
            res.num = RES_NUM_W'(neg ? -longint'(mn / x) : longint'(mn / x));
            res.den = RES_DEN_W'(md / x);
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // Offer one transaction, optionally after an idle burst; keep tvalid up for the next one.
    task automatic send_fraction_op(input logic [ACT_W-1:0] act, input operand_t an,
                                    input operand_t ad, input operand_t bn, input operand_t bd);
        if (src_idle_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= {$urandom, $urandom};
            s_axis_tuser  <= ACT_W'($urandom);
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {bd, bn, ad, an};
        s_axis_tuser  <= act;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        expected_fractions.push_back(reduce_fraction_op(act, an, ad, bn, bd));
    endtask

    // Drop tvalid so the last transaction is not taken again, then wait for all results.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_fractions.size() != 0) @(posedge aclk);
    endtask

    function automatic operand_t pick_operand();
        operand_t v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = operand_t'($urandom);
            4: v = operand_t'(int'($urandom_range(0, 24)) - 12);
            5: v = '0;
            6: begin
                case ($urandom_range(0, 3))
                    0: v = 16'h8000;
                    1: v = 16'h7fff;
                    2: v = 16'hffff;
                    default: v = 16'h0001;
                endcase
            end
            7: begin
                v = operand_t'(16'd1 << $urandom_range(0, 15));
                if ($urandom_range(0, 1) == 1) v = -v;
            end
            default: begin
                v = operand_t'($urandom_range(1, 300) * $urandom_range(1, 100));
                if ($urandom_range(0, 1) == 1) v = -v;
            end
        endcase
        return v;
    endfunction

    task automatic send_random_op();
        send_fraction_op(ACT_W'($urandom_range(0, 3)), pick_operand(), pick_operand(),
                         pick_operand(), pick_operand());
    endtask

    task automatic test_directed();
        send_fraction_op(ACT_MUL, 16'sd1, 16'sd1, 16'sd1, 16'sd1);
        send_fraction_op(ACT_MUL, 16'sd32767, 16'sd1, 16'sd32767, 16'sd1);
        send_fraction_op(ACT_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_fraction_op(ACT_MUL, 16'h8000, 16'sd1, 16'h8000, 16'sd1);
        send_fraction_op(ACT_MUL, 16'sd0, 16'sd5, 16'sd7, 16'sd3);
        send_fraction_op(ACT_MUL, 16'sd3, 16'sd0, 16'sd2, 16'sd5);
        send_fraction_op(ACT_MUL, -16'sd6, 16'sd4, 16'sd2, -16'sd9);
        send_fraction_op(ACT_MUL, -16'sd1, 16'sd32767, 16'sd1, 16'h8000);
        send_fraction_op(ACT_DIV, 16'sd1, 16'sd2, 16'sd0, 16'sd3);
        send_fraction_op(ACT_DIV, 16'sd0, 16'sd2, 16'sd3, 16'sd4);
        send_fraction_op(ACT_DIV, 16'sd5, 16'sd7, -16'sd3, 16'sd11);
        send_fraction_op(ACT_DIV, 16'h8000, 16'sd32767, 16'sd32767, 16'h8000);
        send_fraction_op(ACT_DIV, 16'sd32767, -16'sd1, 16'h8000, 16'h8000);
        send_fraction_op(ACT_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd3);
        send_fraction_op(ACT_ADD, 16'sd1, 16'sd2, -16'sd1, 16'sd2);
        send_fraction_op(ACT_ADD, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_fraction_op(ACT_ADD, 16'sd32767, 16'sd32766, 16'sd32765, 16'sd32764);
        send_fraction_op(ACT_ADD, 16'sd1, 16'sd0, 16'sd1, 16'sd1);
        send_fraction_op(ACT_ADD, 16'h8000, -16'sd1, 16'h8000, -16'sd1);
        send_fraction_op(ACT_SUB, 16'sd3, 16'sd4, 16'sd3, 16'sd4);
        send_fraction_op(ACT_SUB, 16'h8000, 16'sd32767, 16'sd32767, 16'h8000);
        send_fraction_op(ACT_SUB, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_fraction_op(ACT_SUB, 16'sd32767, 16'sd1, 16'h8000, 16'sd1);
        send_fraction_op(ACT_SUB, -16'sd1, -16'sd1, 16'sd1, 16'sd1);
        wait_drained();
    endtask

    // Random operands with idling switched on and off in segments on both sides.
    task automatic test_random_idling();
        for (int i = 0; i < 450; i++) begin
            if (i % 50 == 0) begin
                src_idle_on  = ($urandom_range(0, 3) != 0);
                sink_idle_on <= ($urandom_range(0, 3) != 0);
            end
            send_random_op();
            if (i == 225) wait_drained();
        end
        wait_drained();
    endtask

    // Stall the sink long enough for the block to fill while the source keeps offering.
    task automatic test_sink_hold_off();
        src_idle_on = 1'b0;
        ->hold_off_trigger;
        for (int i = 0; i < 16; i++) send_random_op();
        wait_drained();
    endtask

    task automatic test_streaming_no_idle();
        src_idle_on  = 1'b0;
        sink_idle_on <= 1'b0;
        for (int i = 0; i < 410; i++) send_random_op();
        s_axis_tvalid <= 1'b0;
    endtask

    initial begin : sink_hold_off_proc
        forever begin
            @(hold_off_trigger);
            sink_hold <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            sink_hold <= 1'b0;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            sink_gap_left <= 0;
        end else if (sink_hold) begin
            m_axis_tready <= 1'b0;
        end else if (sink_gap_left != 0) begin
            sink_gap_left <= sink_gap_left - 1;
            m_axis_tready <= 1'b0;
        end else if (sink_idle_on && $urandom_range(0, 11) == 0) begin
            sink_gap_left <= $urandom_range(1, 19) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Compare each result transaction with the oldest pending prediction.
    always @(posedge aclk) begin
        reduced_fraction_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_fractions.size() == 0) begin
                report_mismatch("unexpected result", longint'(m_axis_tdata[RES_NUM_W-1:0]), 0);
            end else begin
                want = expected_fractions.pop_front();
                if (m_axis_tdata[RES_NUM_W-1:0] !== want.num)
                    report_mismatch("res_num", longint'(signed'(m_axis_tdata[RES_NUM_W-1:0])),
                                    longint'(signed'(want.num)));
                if (m_axis_tdata[RES_NUM_W +: RES_DEN_W] !== want.den)
                    report_mismatch("res_den", longint'(m_axis_tdata[RES_NUM_W +: RES_DEN_W]),
                                    longint'(want.den));
                if (m_axis_tuser[0] !== want.err)
                    report_mismatch("zero_den_error", longint'(m_axis_tuser[0]),
                                    longint'(want.err));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random_idling();
        test_sink_hold_off();
        test_streaming_no_idle();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_fractions.size() != 0)
            report_mismatch("results left pending", expected_fractions.size(), 0);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
rtl/rar_pkg.sv
rtl/rational_arith_reduce_unit.sv
rtl/rar_port_chk.sv
tb/tb_top.sv
